[sv/bit_packer_expgolomb_macros.svh]
// Assertion helpers used by the top-level RTL.
`ifndef BIT_PACKER_EXPGOLOMB_MACROS_SVH
`define BIT_PACKER_EXPGOLOMB_MACROS_SVH

// Condition holds at every edge out of reset
`define BPEG_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define BPEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bpeg_pkg.sv]
`default_nettype none
package bpeg_pkg;

    // request codes
    typedef enum logic [2:0] {
        REQ_BE    = 3'd0,
        REQ_LE    = 3'd1,
        REQ_UEG   = 3'd2,
        REQ_SEG   = 3'd3,
        REQ_ALIGN = 3'd4
    } t_req_type;

    typedef enum logic [1:0] {
        F_IDLE,
        F_PREP,
        F_DIV,
        F_SIZE
    } t_front_state;

    // one bit run: the low nbits of val (zeros above bit 63), msb first
    typedef struct packed {
        logic [63:0] val;
        logic [6:0]  nbits;
        logic        err;
    } t_entry;

    localparam int BYTE_SHIFT  = 3;
    localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

[sv/bpeg_queue.sv]
`default_nettype none
module bpeg_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire bpeg_pkg::t_entry  i_wdata,
    output logic                   o_full,
    input  wire logic              i_rd,
    output bpeg_pkg::t_entry       o_rdata,
    output logic                   o_empty
);
    localparam int PW = $clog2(bpeg_pkg::QUEUE_DEPTH);

    bpeg_pkg::t_entry r_mem [bpeg_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(bpeg_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 1'b1;
            if (i_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_wr) - (PW+1)'(i_rd);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_wdata;
    end
endmodule
`default_nettype wire

[sv/bpeg_front.sv]
`default_nettype none
module bpeg_front #(
    parameter int COUNT_WIDTH = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [2:0]        i_req_type,
    input  wire logic [63:0]       i_value,
    input  wire logic [6:0]        i_width,
    output logic                   o_wr,
    output bpeg_pkg::t_entry       o_wdata,
    input  wire logic              i_qfull
);
    localparam int DIW = $clog2(COUNT_WIDTH);

    bpeg_pkg::t_front_state r_state, n_state;
    bpeg_pkg::t_req_type    r_type;
    logic [63:0]            r_value;
    logic [6:0]             r_width;
    logic [63:0]            r_val, n_val;
    logic [6:0]             r_nbits, n_nbits;
    logic                   r_err, n_err;
    logic                   r_exp, n_exp;
    logic                   r_align, n_align;
    logic [7:0]             r_nz, n_nz;
    logic [3:0]             r_rem, n_rem;
    logic [DIW-1:0]         r_didx, n_didx;
    logic [COUNT_WIDTH-1:0] r_total, n_total;

    // request decode helpers
    logic [6:0]  w64;
    logic [3:0]  nbytes;
    logic [2:0]  rest;
    logic [63:0] lj, le_val, code, egmask, egv, v1;
    logic [7:0]  lane, v1nz;
    logic        eg_err;

    always_comb begin
        w64    = (r_width > 7'd64) ? 7'd64 : r_width;
        nbytes = w64[6:3];
        rest   = w64[2:0];
        // bytes in reverse order, partial tail byte left-justified in its slot
        lj = '0;
        for (int s = 0; s < 8; s++) begin
            lane = r_value[8*s +: 8];
            lj[63-8*s -: 8] = (4'(s) == nbytes) ? 8'(lane << (4'd8 - {1'b0, rest})) : lane;
        end
        le_val = lj >> (7'd64 - w64);
        // signed mapping
        if (r_type == bpeg_pkg::REQ_SEG) begin
            if (r_value[63])         code = (64'd0 - r_value) << 1;
            else if (r_value == '0)  code = '0;
            else                     code = (r_value << 1) - 64'd1;
        end else begin
            code = r_value;
        end
        egmask = (w64 == 7'd64) ? '1 : ((64'd1 << w64[5:0]) - 64'd1);
        egv    = code & egmask;
        eg_err = &egv;
        v1     = egv + 64'd1;
        for (int b = 0; b < 8; b++) v1nz[b] = |v1[8*b +: 8];
    end

    // code length helpers
    logic [2:0] top_idx, top_bit;
    logic [7:0] top_byte;
    logic [6:0] rem7, len;
    logic [4:0] dstep, dk;

    always_comb begin
        top_idx = '0;
        for (int b = 0; b < 8; b++) if (r_nz[b]) top_idx = 3'(b);
        top_byte = r_val[8*top_idx +: 8];
        top_bit = '0;
        for (int b = 0; b < 8; b++) if (top_byte[b]) top_bit = 3'(b);
        rem7 = {r_rem, r_total[2:0]};
        if (r_err)         len = '0;
        else if (r_exp)    len = {top_idx, top_bit, 1'b1};
        else if (r_align)  len = (rem7 == '0) ? 7'd0 : (r_width - rem7);
        else               len = r_nbits;
        // one remainder step per cycle over total_bits / 8
        dstep = {r_rem, r_total[r_didx]};
        dk    = {1'b0, r_width[6:3]};
    end

    // next state and outputs
    always_comb begin
        n_state = r_state;
        n_val   = r_val;
        n_nbits = r_nbits;
        n_err   = r_err;
        n_exp   = r_exp;
        n_align = r_align;
        n_nz    = r_nz;
        n_rem   = r_rem;
        n_didx  = r_didx;
        n_total = r_total;
        o_wr    = 1'b0;
        o_wdata = '{val: r_val, nbits: len, err: r_err};
        case (r_state)
            bpeg_pkg::F_IDLE: begin
                if (i_push) n_state = bpeg_pkg::F_PREP;
            end
            bpeg_pkg::F_PREP: begin
                n_val   = r_value;
                n_nbits = '0;
                n_err   = 1'b0;
                n_exp   = 1'b0;
                n_align = 1'b0;
                n_nz    = v1nz;
                n_state = bpeg_pkg::F_SIZE;
                case (r_type)
                    bpeg_pkg::REQ_BE: begin
                        n_nbits = w64;
                    end
                    bpeg_pkg::REQ_LE: begin
                        n_val   = le_val;
                        n_nbits = w64;
                    end
                    bpeg_pkg::REQ_UEG, bpeg_pkg::REQ_SEG: begin
                        n_val = v1;
                        n_err = eg_err;
                        n_exp = 1'b1;
                    end
                    bpeg_pkg::REQ_ALIGN: begin
                        // padding is all zeros
                        n_val = '0;
                        if (r_width[2:0] != '0) begin
                            n_err = 1'b1;
                        end else if (r_width != '0) begin
                            n_align = 1'b1;
                            n_rem   = '0;
                            n_didx  = DIW'(COUNT_WIDTH - 1);
                            n_state = bpeg_pkg::F_DIV;
                        end
                    end
                    default: begin
                        n_nbits = '0;
                    end
                endcase
            end
            bpeg_pkg::F_DIV: begin
                n_rem = (dstep >= dk) ? 4'(dstep - dk) : dstep[3:0];
                if (r_didx == DIW'(bpeg_pkg::BYTE_SHIFT)) n_state = bpeg_pkg::F_SIZE;
                else n_didx = r_didx - 1'b1;
            end
            bpeg_pkg::F_SIZE: begin
                if (!i_qfull) begin
                    o_wr    = 1'b1;
                    n_total = r_total + COUNT_WIDTH'(len);
                    n_state = bpeg_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = bpeg_pkg::F_IDLE;
            end
        endcase
    end

    assign o_full = (r_state != bpeg_pkg::F_IDLE);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpeg_pkg::F_IDLE;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_state == bpeg_pkg::F_IDLE && i_push) begin
            r_type  <= bpeg_pkg::t_req_type'(i_req_type);
            r_value <= i_value;
            r_width <= i_width;
        end
        r_val   <= n_val;
        r_nbits <= n_nbits;
        r_err   <= n_err;
        r_exp   <= n_exp;
        r_align <= n_align;
        r_nz    <= n_nz;
        r_rem   <= n_rem;
        r_didx  <= n_didx;
    end
endmodule
`default_nettype wire

[sv/bpeg_back.sv]
`default_nettype none
module bpeg_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bpeg_pkg::t_entry  i_rdata,
    input  wire logic              i_qempty,
    output logic                   o_rd,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [7:0]             o_out_byte,
    output logic                   o_byte_valid,
    output logic                   o_last,
    output logic                   o_error
);
    logic        r_busy, r_emitted, r_err;
    logic [63:0] r_val;
    logic [6:0]  r_rem;
    logic [7:0]  r_pbyte;
    logic [2:0]  r_pcnt;
    logic        r_oval, r_obv, r_olast, r_oerr;
    logic [7:0]  r_obyte;

    logic        slot_free, step;
    logic [3:0]  avail, k;
    logic [6:0]  rem_n;
    logic [7:0]  chunk, newp;
    logic        complete;

    assign slot_free = !r_oval || i_pop;
    assign step      = r_busy && slot_free;
    assign o_rd      = !r_busy && !i_qempty;

    // take up to the free bits of the partial byte from the run
    always_comb begin
        avail    = 4'd8 - {1'b0, r_pcnt};
        k        = (r_rem < {3'b0, avail}) ? r_rem[3:0] : avail;
        rem_n    = r_rem - {3'b0, k};
        chunk    = 8'(r_val >> rem_n) & 8'((9'd1 << k) - 9'd1);
        newp     = r_pbyte | 8'(chunk << (avail - k));
        complete = (k == avail);
    end

    // run sequencing and partial byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pbyte <= '0;
            r_pcnt  <= '0;
        end else if (o_rd) begin
            r_busy <= 1'b1;
        end else if (step) begin
            if (r_err) begin
                r_busy <= 1'b0;
            end else if (complete) begin
                r_pbyte <= '0;
                r_pcnt  <= '0;
                if (rem_n == '0) r_busy <= 1'b0;
            end else begin
                r_pbyte <= newp;
                r_pcnt  <= r_pcnt + k[2:0];
                r_busy  <= 1'b0;
            end
        end
    end

    // run payload
    always_ff @(posedge i_clk) begin
        if (o_rd) begin
            r_val     <= i_rdata.val;
            r_rem     <= i_rdata.nbits;
            r_err     <= i_rdata.err;
            r_emitted <= 1'b0;
        end else if (step) begin
            r_rem <= rem_n;
            if (complete) r_emitted <= 1'b1;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else begin
            if (i_pop && r_oval) r_oval <= 1'b0;
            if (step) begin
                if (r_err) begin
                    r_oval  <= 1'b1;
                    r_obyte <= '0;
                    r_obv   <= 1'b0;
                    r_olast <= 1'b1;
                    r_oerr  <= 1'b1;
                end else if (complete) begin
                    r_oval  <= 1'b1;
                    r_obyte <= newp;
                    r_obv   <= 1'b1;
                    r_olast <= (rem_n < 7'd8);
                    r_oerr  <= 1'b0;
                end else if (!r_emitted) begin
                    r_oval  <= 1'b1;
                    r_obyte <= '0;
                    r_obv   <= 1'b0;
                    r_olast <= 1'b1;
                    r_oerr  <= 1'b0;
                end
            end
        end
    end

    assign o_empty      = !r_oval;
    assign o_out_byte   = r_obyte;
    assign o_byte_valid = r_obv;
    assign o_last       = r_olast;
    assign o_error      = r_oerr;
endmodule
`default_nettype wire

[sv/bit_packer_expgolomb.sv]
// Flow: an accepted beat is registered, decoded in the prepare state and its bit run written
//   to the queue in the size state, which waits while the queue is full (align first runs a
//   divide state for its remainder, one count bit per cycle); the back loads a run when idle.
// Pace: the front takes no new request until the last one is queued; the back emits one byte
//   per cycle while the output beat is popped, so long codes (up to 16 bytes) set the pace.
// Reset: i_rst_n synchronous, active low; clears the partial byte, bit count and queue.
`default_nettype none
module bit_packer_expgolomb #(
    parameter int COUNT_WIDTH = 48
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [63:0] i_value,
    input  wire logic [6:0]  i_width,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_last,
    output logic             o_error
);
`include "bit_packer_expgolomb_macros.svh"

    bpeg_pkg::t_entry q_wdata, q_rdata;
    logic q_wr, q_full, q_rd, q_empty;

    bpeg_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .i_width    (i_width),
        .o_wr       (q_wr),
        .o_wdata    (q_wdata),
        .i_qfull    (q_full)
    );

    bpeg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    bpeg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rdata      (q_rdata),
        .i_qempty     (q_empty),
        .o_rd         (q_rd),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_error      (o_error)
    );

    // an error beat carries no byte and closes its request
    `BPEG_ASSERT(a_err_beat, empty || !o_error || (o_last && !o_byte_valid), "bad error beat")
    // a beat without a byte is always the final one of its request
    `BPEG_ASSERT(a_nobyte_last, empty || o_byte_valid || (o_last && o_out_byte == 8'd0), "bad empty beat")
    // the queue is never written while full
    `BPEG_ASSERT(a_queue_wr, !(q_wr && q_full), "queue overrun")
    // an accepted beat makes the front busy next cycle
    `BPEG_ASSERT_NEXT(a_front_busy, push && !full, full, "front took two beats")

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;

    typedef struct packed {
        logic [7:0] data;
        logic       vld;
        logic       lst;
        logic       err;
    } t_byte_res;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] val;
        logic [6:0]  wid;
        int          n_exp;   // 0: predictor only; else a single typed-in beat (exp0) is expected
        t_byte_res   exp0;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [2:0]  i_req_type;
    logic [63:0] i_value;
    logic [6:0]  i_width;
    logic        empty;
    logic        pop;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_last;
    logic        o_error;

    bit_packer_expgolomb #(.COUNT_WIDTH(48)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .i_width      (i_width),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_error      (o_error)
    );

    // packer state mirror
    logic [7:0]  pk_byte;
    logic [2:0]  pk_cnt;
    logic [47:0] pk_total;
    t_byte_res   beat_buf[$];
    t_byte_res   pending_bytes[$];
    int          n_mismatch;
    bit          stim_done;
    bit          rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic void put_bit(logic b);
        pk_byte[7 - pk_cnt] = b;
        pk_total = pk_total + 48'd1;
        if (pk_cnt == 3'd7) begin
            beat_buf.push_back('{pk_byte, 1'b1, 1'b0, 1'b0});
            pk_byte = 8'd0;
            pk_cnt = 3'd0;
        end else begin
            pk_cnt = pk_cnt + 3'd1;
        end
    endfunction

    function automatic void put_run(logic [63:0] v, int n);
        for (int i = n; i > 0; i--) put_bit(v[i - 1]);
    endfunction

    // returns 0 when the code overflows
    function automatic bit put_golomb(logic [63:0] code, int w);
        logic [63:0] v;
        logic [63:0] v1;
        int m;
        v = (w >= 64) ? code : (code & ((64'd1 << w) - 64'd1));
        if (v == '1) return 1'b0;
        v1 = v + 64'd1;
        m = 0;
        for (int i = 0; i < 64; i++) if (v1[i]) m = i;
        put_run(64'd0, m);
        put_run(v1, m + 1);
        return 1'b1;
    endfunction

    // predicted bytes of one request, appended to pending_bytes
    task automatic predict_request(logic [2:0] op, logic [63:0] val, logic [6:0] wid);
        int w;
        bit ok;
        logic [63:0] code;
        logic [47:0] rem;
        logic [7:0] sv_byte;
        logic [2:0] sv_cnt;
        logic [47:0] sv_total;
        w = (wid > 7'd64) ? 64 : int'(wid);
        ok = 1'b1;
        sv_byte = pk_byte;
        sv_cnt = pk_cnt;
        sv_total = pk_total;
        beat_buf.delete();
        case (op)
            bpeg_pkg::REQ_BE: put_run(val, w);
            bpeg_pkg::REQ_LE: begin
                for (int i = 0; i < w / 8; i++) put_run((val >> (8 * i)) & 64'hFF, 8);
                if ((w % 8) != 0 && (w / 8) < 8)
                    put_run(val >> (8 * (w / 8)), w % 8);
            end
            bpeg_pkg::REQ_UEG: ok = put_golomb(val, w);
            bpeg_pkg::REQ_SEG: begin
                if (val[63]) code = (64'd0 - val) << 1;
                else if (val == 64'd0) code = 64'd0;
                else code = (val << 1) - 64'd1;
                ok = put_golomb(code, w);
            end
            bpeg_pkg::REQ_ALIGN: begin
                if (wid[2:0] != 3'd0) begin
                    ok = 1'b0;
                end else if (wid != 7'd0) begin
                    rem = pk_total % 48'(wid);
                    if (rem != 48'd0)
                        for (int i = 0; i < int'(48'(wid) - rem); i++) put_bit(1'b0);
                end
            end
            default: ;
        endcase
        if (!ok) begin
            pk_byte = sv_byte;
            pk_cnt = sv_cnt;
            pk_total = sv_total;
            beat_buf.delete();
            beat_buf.push_back('{8'd0, 1'b0, 1'b0, 1'b1});
        end else if (beat_buf.size() == 0) begin
            beat_buf.push_back('{8'd0, 1'b0, 1'b0, 1'b0});
        end
        beat_buf[beat_buf.size() - 1].lst = 1'b1;
        foreach (beat_buf[i]) pending_bytes.push_back(beat_buf[i]);
    endtask

    // push stays high across back-to-back beats; it drops only for an idle gap
    task automatic send_request(logic [2:0] op, logic [63:0] val, logic [6:0] wid);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_req_type <= op;
        i_value <= val;
        i_width <= wid;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_request(op, val, wid);
    endtask

    // directed rows; typed-in expectations only where obvious
    t_dir_row dir_rows[] = '{
        '{bpeg_pkg::REQ_BE,    64'hA5,                  7'd8,   1, '{8'hA5, 1, 1, 0}},
        '{bpeg_pkg::REQ_BE,    64'h0,                   7'd0,   1, '{8'h00, 0, 1, 0}},
        '{bpeg_pkg::REQ_ALIGN, 64'h0,                   7'd3,   1, '{8'h00, 0, 1, 1}},
        '{bpeg_pkg::REQ_UEG,   '1,                      7'd64,  1, '{8'h00, 0, 1, 1}},
        '{bpeg_pkg::REQ_UEG,   '1,                      7'd100, 1, '{8'h00, 0, 1, 1}},
        '{3'd7,                64'h1234,                7'd12,  1, '{8'h00, 0, 1, 0}},
        '{3'd5,                '1,                      7'd127, 1, '{8'h00, 0, 1, 0}},
        '{bpeg_pkg::REQ_ALIGN, 64'h0,                   7'd0,   1, '{8'h00, 0, 1, 0}},
        '{bpeg_pkg::REQ_BE,    '1,                      7'd64,  0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_BE,    64'h5,                   7'd3,   0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_ALIGN, 64'h0,                   7'd8,   0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_LE,    64'h0123456789ABCDEF,    7'd64,  0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_LE,    64'h0123456789ABCDEF,    7'd13,  0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_LE,    '1,                      7'd127, 0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_UEG,   64'h0,                   7'd5,   0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_UEG,   64'hFFFF_FFFF_FFFF_FFFE, 7'd64,  0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_UEG,   '1,                      7'd0,   0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_UEG,   '1,                      7'd63,  0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_SEG,   64'h0,                   7'd64,  0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_SEG,   64'h8000_0000_0000_0000, 7'd64,  0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_SEG,   64'h7FFF_FFFF_FFFF_FFFF, 7'd64,  0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_SEG,   '1,                      7'd7,   0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_ALIGN, 64'h0,                   7'd120, 0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_ALIGN, 64'h0,                   7'd64,  0, '{8'h00, 0, 0, 0}},
        '{bpeg_pkg::REQ_ALIGN, 64'h0,                   7'd127, 0, '{8'h00, 0, 0, 0}}
    };

    // stimulus
    initial begin
        logic [2:0]  op;
        logic [63:0] val;
        logic [6:0]  wid;
        int          sel;
        push = 1'b0;
        i_req_type = 3'd0;
        i_value = 64'd0;
        i_width = 7'd0;
        i_rst_n = 1'b0;
        pk_byte = 8'd0;
        pk_cnt = 3'd0;
        pk_total = 48'd0;
        n_mismatch = 0;
        stim_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].op, dir_rows[i].val, dir_rows[i].wid);
            if (dir_rows[i].n_exp != 0 &&
                (beat_buf.size() != 1 || beat_buf[0] != dir_rows[i].exp0)) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("row %0d: exp %h v%b l%b e%b got %0d beats, %h v%b l%b e%b",
                             i, dir_rows[i].exp0.data, dir_rows[i].exp0.vld,
                             dir_rows[i].exp0.lst, dir_rows[i].exp0.err,
                             beat_buf.size(), beat_buf[0].data, beat_buf[0].vld,
                             beat_buf[0].lst, beat_buf[0].err);
            end
        end
        for (int k = 0; k < 185; k++) begin
            sel = $urandom_range(0, 19);
            op = (sel < 18) ? 3'(sel % 5) : 3'($urandom_range(5, 7));
            val = {$urandom(), $urandom()};
            // mostly small magnitudes so golomb codes stay short
            if ($urandom_range(0, 2) != 0) val = val >> $urandom_range(0, 63);
            if (op == bpeg_pkg::REQ_SEG && $urandom_range(0, 1) == 1) val = -val;
            if ($urandom_range(0, 3) == 0) wid = 7'($urandom_range(0, 127));
            else wid = 7'($urandom_range(0, 64));
            if (op == bpeg_pkg::REQ_ALIGN && $urandom_range(0, 3) != 0)
                wid = 7'(8 * $urandom_range(0, 15));
            send_request(op, val, wid);
        end
        push <= 1'b0;
        stim_done = 1'b1;
    end

    // long receiver hold-off early in the random part
    initial begin
        rx_hold = 1'b0;
        wait (i_rst_n);
        repeat (600) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // result side: random pop stalls and checking
    initial begin
        int stall;
        t_byte_res got;
        t_byte_res want;
        pop = 1'b0;
        wait (i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall > 0 || rx_hold) pop <= 1'b0;
            repeat (stall) @(posedge i_clk);
            while (rx_hold) @(posedge i_clk);
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            got = '{o_out_byte, o_byte_valid, o_last, o_error};
            if (pending_bytes.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected beat: got %h v%b l%b e%b",
                             got.data, got.vld, got.lst, got.err);
            end else begin
                want = pending_bytes.pop_front();
                if (got != want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp %h v%b l%b e%b got %h v%b l%b e%b",
                                 want.data, want.vld, want.lst, want.err,
                                 got.data, got.vld, got.lst, got.err);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_mismatch == 0 && pending_bytes.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
+incdir+sv
sv/bpeg_pkg.sv
sv/bpeg_queue.sv
sv/bpeg_front.sv
sv/bpeg_back.sv
sv/bit_packer_expgolomb.sv
tb/tb.sv
